[hw/rtl/jlws_pkg.sv]
// Shared constants, types and the logistic table builder for the joint limit weight scaler.
// No dependencies; every other file in hw/rtl imports this package.
package jlws_pkg;

  localparam int NUM_JOINTS         = 16;
  localparam int JIDX_W             = $clog2(NUM_JOINTS);
  // The table depth is a power of two: the divider scales the distance by shifting.
  localparam int LOGISTIC_ROM_DEPTH = 1024;
  localparam int ROM_AW             = $clog2(LOGISTIC_ROM_DEPTH);

  localparam int POS_W = 32;
  localparam int Q16_W = 17;
  localparam int CFG_W = 17;

  localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [CFG_W-1:0] SMOOTH_RESET = 17'd52429;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // Input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_APPLY = 1'b1;

  // Register indexes
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_SMOOTH = 1'b1;

  // Zone codes
  localparam logic [2:0] ZONE_FREE  = 3'd0;
  localparam logic [2:0] ZONE_BELOW = 3'd1;
  localparam logic [2:0] ZONE_ABOVE = 3'd2;
  localparam logic [2:0] ZONE_LOWER = 3'd3;
  localparam logic [2:0] ZONE_UPPER = 3'd4;
  localparam logic [2:0] ZONE_LOAD  = 3'd5;

  typedef struct packed {
    logic              done;
    logic [ROM_AW-1:0] quot;
  } div_res_t;

  typedef logic [Q16_W-1:0] rom_arr_t [LOGISTIC_ROM_DEPTH];

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned dvs);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = (r << 1) | ((num >> i) & 64'd1);
      if (r >= dvs) begin
        r = r - dvs;
        q = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // Entry k: round(65536 / (1 + e^x)), x = 12k/DEPTH - 6, evaluated in Q30.
  function automatic logic [Q16_W-1:0] logistic_entry(input int unsigned k);
    longint          x;
    longint unsigned t;
    longint unsigned u;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned den;
    longint unsigned g;
    int unsigned     n;
    x = longint'((64'd12 * 64'(k) * Q30_ONE) >> ROM_AW) - longint'(6 * Q30_ONE);
    t = (x < 0) ? longint'(-x) : longint'(x);
    u = t >> 6;
    term = Q30_ONE;
    sum  = Q30_ONE;
    for (n = 1; n <= 5; n++) begin
      term = udiv64((term * u) >> 30, 64'(n));
      if ((n & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    // square up six times to undo the divide by 64
    for (n = 0; n < 6; n++) begin
      sum = (sum * sum) >> 30;
    end
    den = Q30_ONE + sum;
    g = udiv64((sum << 16) + (den >> 1), den);
    if (x >= 0) return Q16_W'(g);
    return Q16_W'(64'd65536 - g);
  endfunction

  function automatic rom_arr_t build_logistic_rom();
    rom_arr_t rom;
    for (int unsigned k = 0; k < LOGISTIC_ROM_DEPTH; k++) begin
      rom[k] = logistic_entry(k);
    end
    return rom;
  endfunction

endpackage

[hw/rtl/joint_limit_weight_scaler_top.sv]
// Top level of the joint limit weight scaler: sequencer, per-joint tables, shared multiplier.
// Depends on jlws_pkg, jlws_div and jlws_rom.
//
// Usage:
//   Input: drive in_* and raise start; a beat is taken at a rising edge with start high
//   and busy low. cmd 0 loads a joint's limits and base weight, cmd 1 applies a position.
//   Result: one beat per command on out_*, marked by out_valid for exactly one cycle.
//   The receiver cannot stall; the result must be taken in that cycle.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes a register. The user must
//   write it only while the block is idle; the block itself does not enforce it.
// Paths: a load writes the joint's tables; an apply outside a limit or in the free zone
//   skips the divider; an apply inside an avoidance zone runs the divider and the table,
//   and the smoothing step only when the scaling rises. The index saturates at once
//   (depth at least the zone size, or a zero size).
//   The in-zone path runs through the 10-step restoring divider (one quotient bit per
//   cycle for a 1024-entry table) and the one multiplier shared by the load, smoothing
//   and weighting steps. busy is high from the accepting edge until out_valid rises;
//   a new start is taken in the out_valid cycle.
// Reset: synchronous, active low. Registers return to their defaults and every joint's
//   previous scaling to 1.0; limits and weights hold no value until a joint is loaded.
module joint_limit_weight_scaler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [3:0]                        in_joint,
  input  logic signed [jlws_pkg::POS_W-1:0] in_position,
  input  logic signed [jlws_pkg::POS_W-1:0] in_limit_low,
  input  logic signed [jlws_pkg::POS_W-1:0] in_limit_high,
  input  logic [jlws_pkg::Q16_W-1:0]        in_base_weight,
  output logic                              out_valid,
  output logic [3:0]                        out_joint_out,
  output logic [2:0]                        out_zone,
  output logic [jlws_pkg::Q16_W-1:0]        out_scaling,
  output logic [jlws_pkg::Q16_W-1:0]        out_weighted,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [jlws_pkg::CFG_W-1:0]        cfg_wdata
);
  import jlws_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LMUL  = 4'd1;
  localparam logic [3:0] S_LWR   = 4'd2;
  localparam logic [3:0] S_CLASS = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_ROM   = 4'd5;
  localparam logic [3:0] S_ROMW  = 4'd6;
  localparam logic [3:0] S_SMUL  = 4'd7;
  localparam logic [3:0] S_SFIX  = 4'd8;
  localparam logic [3:0] S_WMUL  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam int MUL_W = POS_W + Q16_W;

  // configuration
  logic [CFG_W-1:0] window_r;
  logic [CFG_W-1:0] smooth_r;
  logic [CFG_W-1:0] cfg_sat;

  // per-joint tables
  logic signed [POS_W-1:0] low_tab       [NUM_JOINTS];
  logic signed [POS_W-1:0] high_tab      [NUM_JOINTS];
  logic        [POS_W-1:0] size_tab      [NUM_JOINTS];
  logic signed [POS_W-1:0] inner_lo_tab  [NUM_JOINTS];
  logic signed [POS_W-1:0] inner_hi_tab  [NUM_JOINTS];
  logic        [Q16_W-1:0] weight_tab    [NUM_JOINTS];
  logic        [Q16_W-1:0] prev_tab      [NUM_JOINTS];

  // sequencer and latched beat
  logic [3:0]              state_r;
  logic [3:0]              state_nxt;
  logic [3:0]              joint_r;
  logic signed [POS_W-1:0] pos_r;
  logic signed [POS_W-1:0] lo_r;
  logic signed [POS_W-1:0] hi_r;
  logic [Q16_W-1:0]        bw_r;
  logic [2:0]              zone_r;
  logic [Q16_W-1:0]        s_r;

  // shared multiplier
  logic [POS_W-1:0] mul_a;
  logic [Q16_W-1:0] mul_b;
  logic [MUL_W-1:0] prod_r;

  // outputs
  logic             out_valid_r;
  logic [3:0]       out_joint_r;
  logic [2:0]       out_zone_r;
  logic [Q16_W-1:0] out_scaling_r;
  logic [Q16_W-1:0] out_weighted_r;

  logic              accept;
  logic [JIDX_W-1:0] jidx;
  logic              div_start;
  div_res_t          div_res;
  logic [Q16_W-1:0]  rom_data;

  // load datapath
  logic signed [POS_W:0] span_diff;
  logic [POS_W-1:0]      span;
  logic [POS_W-1:0]      size_new;
  logic signed [POS_W+1:0] ilo_sum;
  logic signed [POS_W+1:0] ihi_sum;

  // classification
  logic                  p_le_lo;
  logic                  p_ge_hi;
  logic                  p_lt_ilo;
  logic                  p_gt_ihi;
  logic signed [POS_W:0] d_lo;
  logic signed [POS_W:0] d_hi;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W+1:0] v);
    if (v[POS_W+1:POS_W-1] == 3'b000 || v[POS_W+1:POS_W-1] == 3'b111) begin
      return v[POS_W-1:0];
    end
    if (v[POS_W+1]) return {1'b1, {(POS_W-1){1'b0}}};
    return {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy && ({1'b0, in_joint} < 5'(NUM_JOINTS));
  assign jidx   = joint_r[JIDX_W-1:0];

  assign cfg_sat = (cfg_wdata > Q16_ONE) ? Q16_ONE : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      smooth_r <= SMOOTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW: window_r <= cfg_sat;
        REG_SMOOTH: smooth_r <= cfg_sat;
        default:    ;
      endcase
    end
  end

  // load: size = |high - low| * window >> 16, bounds pulled in by size
  assign span_diff = {hi_r[POS_W-1], hi_r} - {lo_r[POS_W-1], lo_r};
  assign span      = span_diff[POS_W] ? POS_W'(-span_diff) : span_diff[POS_W-1:0];
  assign size_new  = prod_r[POS_W+15:16];
  assign ilo_sum   = {{2{lo_r[POS_W-1]}}, lo_r} + {2'b00, size_new};
  assign ihi_sum   = {{2{hi_r[POS_W-1]}}, hi_r} - {2'b00, size_new};

  // apply: classify against the joint's stored bounds
  assign p_le_lo  = pos_r <= low_tab[jidx];
  assign p_ge_hi  = pos_r >= high_tab[jidx];
  assign p_lt_ilo = pos_r < inner_lo_tab[jidx];
  assign p_gt_ihi = pos_r > inner_hi_tab[jidx];
  assign d_lo = {inner_lo_tab[jidx][POS_W-1], inner_lo_tab[jidx]} - {pos_r[POS_W-1], pos_r};
  assign d_hi = {pos_r[POS_W-1], pos_r} - {inner_hi_tab[jidx][POS_W-1], inner_hi_tab[jidx]};

  assign div_start = (state_r == S_CLASS) && !p_le_lo && !p_ge_hi && (p_lt_ilo || p_gt_ihi);

  jlws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (p_lt_ilo ? d_lo[POS_W:0] : d_hi[POS_W:0]),
    .divisor  (size_tab[jidx]),
    .res      (div_res)
  );

  jlws_rom u_rom (
    .clk   (clk),
    .addr  (div_res.quot),
    .rdata (rom_data)
  );

  // operand select for the one multiplier
  always_comb begin
    unique case (state_r)
      S_LMUL: begin
        mul_a = span;
        mul_b = window_r;
      end
      S_SMUL: begin
        mul_a = POS_W'(Q16_ONE - s_r);
        mul_b = smooth_r;
      end
      default: begin
        mul_a = POS_W'(weight_tab[jidx]);
        mul_b = s_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = (in_cmd == CMD_LOAD) ? S_LMUL : S_CLASS;
      S_LMUL:  state_nxt = S_LWR;
      S_LWR:   state_nxt = S_IDLE;
      S_CLASS: state_nxt = div_start ? S_DIV : S_WMUL;
      S_DIV:   if (div_res.done) state_nxt = S_ROM;
      S_ROM:   state_nxt = S_ROMW;
      S_ROMW:  state_nxt = (rom_data > prev_tab[jidx]) ? S_SMUL : S_WMUL;
      S_SMUL:  state_nxt = S_SFIX;
      S_SFIX:  state_nxt = S_WMUL;
      S_WMUL:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch the beat and carry the working values
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        joint_r <= in_joint;
        pos_r   <= in_position;
        lo_r    <= in_limit_low;
        hi_r    <= in_limit_high;
        bw_r    <= (in_base_weight > Q16_ONE) ? Q16_ONE : in_base_weight;
      end
      S_CLASS: begin
        priority if (p_le_lo) begin
          zone_r <= ZONE_BELOW;
          s_r    <= '0;
        end else if (p_ge_hi) begin
          zone_r <= ZONE_ABOVE;
          s_r    <= '0;
        end else if (p_lt_ilo) begin
          zone_r <= ZONE_LOWER;
        end else if (p_gt_ihi) begin
          zone_r <= ZONE_UPPER;
        end else begin
          zone_r <= ZONE_FREE;
          s_r    <= Q16_ONE;
        end
      end
      S_ROMW:  s_r <= rom_data;
      // smoothed rise: 1 - smoothing * (1 - s)
      S_SFIX:  s_r <= Q16_ONE - prod_r[32:16];
      default: ;
    endcase
  end

  // per-joint tables; only the previous scaling has a reset value
  always_ff @(posedge clk) begin
    if (state_r == S_LWR) begin
      low_tab[jidx]      <= lo_r;
      high_tab[jidx]     <= hi_r;
      size_tab[jidx]     <= size_new;
      inner_lo_tab[jidx] <= sat32(ilo_sum);
      inner_hi_tab[jidx] <= sat32(ihi_sum);
      weight_tab[jidx]   <= bw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        prev_tab[i] <= Q16_ONE;
      end
    end else if (state_r == S_OUT) begin
      prev_tab[jidx] <= s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_LWR) || (state_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LWR) begin
      out_joint_r    <= joint_r;
      out_zone_r     <= ZONE_LOAD;
      out_scaling_r  <= '0;
      out_weighted_r <= '0;
    end else if (state_r == S_OUT) begin
      out_joint_r    <= joint_r;
      out_zone_r     <= zone_r;
      out_scaling_r  <= s_r;
      out_weighted_r <= prod_r[32:16];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_joint_out = out_joint_r;
  assign out_zone      = out_zone_r;
  assign out_scaling   = out_scaling_r;
  assign out_weighted  = out_weighted_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zone == ZONE_LOAD |-> out_scaling == '0 && out_weighted == '0)
    else $error("load acknowledge carries nonzero scaling");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scaling <= Q16_ONE && out_weighted <= Q16_ONE)
    else $error("scaling or weighted result above 1.0");

endmodule

[hw/rtl/jlws_rom.sv]
// Logistic lookup table: constant contents from jlws_pkg, registered read.
// Depends on jlws_pkg.
module jlws_rom (
  input  logic                       clk,
  input  logic [jlws_pkg::ROM_AW-1:0] addr,
  output logic [jlws_pkg::Q16_W-1:0]  rdata
);
  import jlws_pkg::*;

  localparam rom_arr_t ROM = build_logistic_rom();

  logic [Q16_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    rdata_r <= ROM[addr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/jlws_div.sv]
// Restoring divider, one quotient bit per cycle: floor(dividend * DEPTH / divisor),
// capped at DEPTH-1. Depends on jlws_pkg.
module jlws_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [32:0]              dividend,
  input  logic [31:0]              divisor,
  output jlws_pkg::div_res_t       res
);
  import jlws_pkg::*;

  localparam int CNT_W = $clog2(ROM_AW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [31:0]       rem_r;
  logic [31:0]       divisor_r;
  logic [ROM_AW-1:0] quot_r;

  logic [32:0] rem2;
  logic        ge;
  logic [31:0] rem_nxt;

  assign rem2    = {rem_r, 1'b0};
  assign ge      = rem2 >= {1'b0, divisor_r};
  assign rem_nxt = ge ? 32'(rem2 - {1'b0, divisor_r}) : rem2[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // quotient would reach DEPTH or more: saturate at once
        if (divisor == 32'd0 || dividend >= {1'b0, divisor}) begin
          quot_r <= '1;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          rem_r     <= dividend[31:0];
          divisor_r <= divisor;
          quot_r    <= '0;
          cnt_r     <= CNT_W'(ROM_AW);
          busy_r    <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[ROM_AW-2:0], ge};
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule
